>>> rtl/gsa_pkg.sv
// Package for the generational slot allocator.
// Holds request/status codes, payload structs and the queue entry type.
package gsa_pkg;

  localparam int unsigned SlotCount = 256;
  localparam int unsigned IdxBits   = 8;
  localparam int unsigned GenBits   = 15;
  localparam int unsigned RefBits   = 16;
  localparam int unsigned CntBits   = 9;
  localparam int unsigned QDepth    = 2;

  typedef enum logic [2:0] {
    REQ_ALLOC   = 3'd0,
    REQ_LOOKUP  = 3'd1,
    REQ_INC     = 3'd2,
    REQ_DEC     = 3'd3,
    REQ_COLLECT = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ACCESS,
    OP_ALLOC,
    OP_COLLECT,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [IdxBits-1:0] slot_index;
    logic [GenBits-1:0] handle_generation;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdxBits-1:0] out_index;
    logic [GenBits-1:0] out_generation;
    logic [RefBits-1:0] ref_count;
    logic [CntBits-1:0] freed_count;
    logic [CntBits-1:0] live_count;
  } rsp_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [2:0]         req_type;
    logic [IdxBits-1:0] slot_index;
    logic [GenBits-1:0] handle_generation;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC,
    BK_SWEEP_RD,
    BK_SWEEP_WR,
    BK_RESP
  } bk_state_e;

endpackage

>>> rtl/generational_slot_allocator_unit.sv
// Generational slot allocator top level: front classifier, command queue, back end.
// Path: an allocate, lookup or count request passes the front queue, then back-end READ, EXEC and RESP.
// The back end takes one command at a time, only from idle; a waiting result holds the next one.
// Collect sweeps every slot in the pool through SWEEP_RD and SWEEP_WR; unknown requests go to RESP.
// Reset is asynchronous, active low, and empties the pool at once through valid bits.
// Depends on gsa_pkg, gsa_front and gsa_back.
module generational_slot_allocator_unit import gsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  gsa_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_ready_o(in_ready_o), .req_i(in_data_i),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  gsa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i), .rsp_o(out_data_o)
  );

endmodule

>>> rtl/gsa_front.sv
// Front end: accepts requests and classifies them into commands.
// Depends on gsa_pkg.
module gsa_front import gsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  cmd_t        q_mem [QDepth];
  logic [1:0]  cnt_q, cnt_d;
  logic        wr_q, wr_d, rd_q, rd_d;
  cmd_t        cls;
  logic        push, pop;

  // Decode the request type into a back-end operation.
  always_comb begin
    cls.req_type          = req_i.req_type;
    cls.slot_index        = req_i.slot_index;
    cls.handle_generation = req_i.handle_generation;
    case (req_i.req_type)
      REQ_ALLOC:                    cls.op = OP_ALLOC;
      REQ_LOOKUP, REQ_INC, REQ_DEC: cls.op = OP_ACCESS;
      REQ_COLLECT:                  cls.op = OP_COLLECT;
      default:                      cls.op = OP_NOP;
    endcase
  end

  assign req_ready_o = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];
  assign push        = req_valid_i && req_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue pointer and count update.
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

>>> rtl/gsa_back.sv
// Back end: slot table, free-index queue, and the command sequencer.
// Depends on gsa_pkg.
module gsa_back import gsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  // Slot table memory: in-use, generation, count. Valid bits give reset value.
  logic [GenBits+RefBits:0] tbl_mem [SlotCount];
  logic [SlotCount-1:0]     vld_q;
  logic [GenBits+RefBits:0] rd_data_q;
  logic                     rd_vld_q;
  logic [IdxBits-1:0]       free_mem [SlotCount];
  logic [IdxBits-1:0]       fq_rd_q;

  bk_state_e          state_q, state_d;
  cmd_t               cmd_q;
  logic [IdxBits-1:0] head_q, tail_q;
  logic [CntBits-1:0] fill_q, pool_q, live_q, freed_q, sweep_q;
  rsp_t               rsp_q, rsp_d;
  logic               rsp_vld_q;

  logic               cmd_acc;
  logic               rd_en, wr_en, fq_wr;
  logic [IdxBits-1:0] rd_addr, wr_addr;
  logic [GenBits+RefBits:0] wr_data;
  logic               use_free;
  logic               ent_use;
  logic [GenBits-1:0] ent_gen, bump, agen;
  logic [RefBits-1:0] ent_ref, new_ref;
  logic               hnd_ok;

  assign ent_use = rd_vld_q & rd_data_q[GenBits+RefBits];
  assign ent_gen = rd_vld_q ? rd_data_q[GenBits+RefBits-1:RefBits] : '0;
  assign ent_ref = rd_vld_q ? rd_data_q[RefBits-1:0] : '0;
  assign bump    = ent_gen + GenBits'(1);
  assign agen    = (bump == '0) ? GenBits'(1) : bump;
  assign use_free = (fill_q != '0);
  assign hnd_ok  = (cmd_q.handle_generation != '0)
                && ({1'b0, cmd_q.slot_index} < pool_q)
                && ent_use && (ent_gen == cmd_q.handle_generation);

  // A new command is taken only once the previous result has left.
  assign cmd_ready_o = (state_q == BK_IDLE) && (!rsp_vld_q || rsp_ready_i);
  assign cmd_acc     = cmd_valid_i && cmd_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (cmd_acc) begin
        case (cmd_i.op)
          OP_COLLECT: state_d = BK_SWEEP_RD;
          OP_NOP:     state_d = BK_RESP;
          default:    state_d = BK_READ;
        endcase
      end
      BK_READ:     state_d = BK_EXEC;
      BK_EXEC:     state_d = BK_RESP;
      BK_SWEEP_RD: state_d = (sweep_q >= pool_q) ? BK_RESP : BK_SWEEP_WR;
      BK_SWEEP_WR: state_d = BK_SWEEP_RD;
      BK_RESP:     if (!rsp_vld_q || rsp_ready_i) state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  // Read address for the table.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmd_q.slot_index;
    if (state_q == BK_READ) begin
      rd_en = 1'b1;
      if (cmd_q.op == OP_ALLOC) begin
        rd_addr = use_free ? fq_rd_q : pool_q[IdxBits-1:0];
      end
    end else if (state_q == BK_SWEEP_RD && sweep_q < pool_q) begin
      rd_en   = 1'b1;
      rd_addr = sweep_q[IdxBits-1:0];
    end
  end

  // Write port and response formation.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_q.slot_index;
    wr_data = rd_data_q;
    fq_wr   = 1'b0;
    rsp_d   = rsp_q;
    new_ref = ent_ref;
    if (cmd_q.req_type == REQ_INC && ent_ref != '1) new_ref = ent_ref + RefBits'(1);
    if (cmd_q.req_type == REQ_DEC && ent_ref != '0) new_ref = ent_ref - RefBits'(1);
    case (state_q)
      BK_EXEC: begin
        if (cmd_q.op == OP_ALLOC) begin
          wr_addr = use_free ? fq_rd_q : pool_q[IdxBits-1:0];
          if (!use_free && pool_q == CntBits'(SlotCount)) begin
            rsp_d = '{ST_FULL, '0, '0, '0, '0, live_q};
          end else begin
            wr_en   = 1'b1;
            wr_data = {1'b1, agen, RefBits'(1)};
            rsp_d   = '{ST_OK, wr_addr, agen, RefBits'(1), '0, live_q + CntBits'(1)};
          end
        end else if (!hnd_ok) begin
          rsp_d = '{ST_BAD, cmd_q.slot_index, '0, '0, '0, live_q};
        end else begin
          wr_en   = 1'b1;
          wr_data = {1'b1, ent_gen, new_ref};
          rsp_d   = '{ST_OK, cmd_q.slot_index, ent_gen, new_ref, '0, live_q};
        end
      end
      BK_SWEEP_WR: begin
        wr_addr = sweep_q[IdxBits-1:0];
        if (ent_use && ent_ref == '0) begin
          wr_en   = 1'b1;
          fq_wr   = 1'b1;
          wr_data = {1'b0, bump, ent_ref};
        end
      end
      BK_SWEEP_RD: rsp_d = '{ST_OK, '0, '0, '0, freed_q, live_q};
      BK_IDLE:     rsp_d = '{ST_OK, '0, '0, '0, '0, live_q};
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      pool_q    <= '0;
      live_q    <= '0;
      freed_q   <= '0;
      sweep_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) rd_vld_q <= vld_q[rd_addr];
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (state_q == BK_RESP && state_d == BK_IDLE) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_vld_q && rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
      if (cmd_acc) begin
        sweep_q <= '0;
        freed_q <= '0;
      end
      if (state_q == BK_EXEC && cmd_q.op == OP_ALLOC && wr_en) begin
        live_q <= live_q + CntBits'(1);
        if (use_free) begin
          head_q <= head_q + IdxBits'(1);
          fill_q <= fill_q - CntBits'(1);
        end else begin
          pool_q <= pool_q + CntBits'(1);
        end
      end
      if (state_q == BK_SWEEP_WR) begin
        sweep_q <= sweep_q + CntBits'(1);
        if (fq_wr) begin
          tail_q  <= tail_q + IdxBits'(1);
          fill_q  <= fill_q + CntBits'(1);
          freed_q <= freed_q + CntBits'(1);
          live_q  <= live_q - CntBits'(1);
        end
      end
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk_i) begin
    if (cmd_acc) cmd_q <= cmd_i;
    if (state_q == BK_EXEC || (cmd_acc && cmd_i.op == OP_NOP) ||
        (state_q == BK_SWEEP_RD && state_d == BK_RESP)) rsp_q <= rsp_d;
    if (rd_en) rd_data_q <= tbl_mem[rd_addr];
    if (wr_en) tbl_mem[wr_addr] <= wr_data;
    fq_rd_q <= free_mem[head_q];
    if (fq_wr) free_mem[tail_q] <= sweep_q[IdxBits-1:0];
  end

endmodule

>>> rtl/gsa_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
// Depends on gsa_pkg.
module gsa_checker import gsa_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Status is never an undefined code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("bad status code");

  // Only collect reports freed slots; such a result has zero generation and count fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.freed_count != '0 |->
      out_data_o.out_generation == '0 && out_data_o.ref_count == '0)
    else $error("freed count with handle fields");

  // A successful allocation or access with a nonzero count never returns generation zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK && out_data_o.ref_count != '0 |->
      out_data_o.out_generation != '0)
    else $error("live slot with generation zero");

endmodule

bind generational_slot_allocator_unit gsa_checker u_gsa_checker (.*);
